@@ hw/rtl/ultrasonic_echo_ranger_defines.svh @@
// Assertion macros for the ultrasonic echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define UER_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("uer assertion failed");
// Next-cycle implication, checked out of reset.
`define UER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("uer assertion failed");
`else
`define UER_ASSERT_IMPL(label, ante, cons)
`define UER_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/uer_pkg.sv @@
// Types and constants shared by the ultrasonic echo ranger modules.
package uer_pkg;

    // Measurement phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_TRIGGER   = 4'b0010,
        PH_WAIT_RISE = 4'b0100,
        PH_MEASURE   = 4'b1000
    } phase_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_TIMEOUT = 1'b0,
        CFG_TRIGGER = 1'b1
    } cfg_idx_t;

    localparam int TICK_W    = 16;
    localparam int PULSE_W   = 8;
    localparam int DIST_W    = 16;
    localparam int CFG_W     = 16;

    localparam logic [TICK_W-1:0]  TIMEOUT_RESET    = 16'd12500;
    localparam logic [PULSE_W-1:0] TRIGGER_RESET    = 8'd3;
    localparam logic [DIST_W-1:0]  TIMEOUT_DISTANCE = 16'hFFFF;
    localparam logic [TICK_W-1:0]  TICK_MAX         = 16'hFFFF;

    // count * 343 / 500 == (count * DIST_MULT) >> DIST_SHIFT for every 16-bit count
    localparam int              DIST_SHIFT  = 26;
    localparam int              DIST_MULT_W = 26;
    localparam logic [DIST_MULT_W-1:0] DIST_MULT = 26'd46036681;
    localparam int              PROD_W      = TICK_W + DIST_MULT_W;

    // One result item
    typedef struct packed {
        logic [DIST_W-1:0] distance_mm;
        logic              timed_out;
        logic              done_res;
        logic              busy_res;
        logic              trigger_out;
    } result_t;

endpackage

@@ hw/rtl/uer_out_buf.sv @@
// Two-entry result buffer between the ranger core and the output channel.
module uer_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  uer_pkg::result_t push_data,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output uer_pkg::result_t out_data
);

    logic [1:0]       count_reg, count_next;
    uer_pkg::result_t head_reg;
    uer_pkg::result_t tail_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign in_ready  = (count_reg != 2'd2);
    assign out_data  = head_reg;

    // Occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Data slots: head is what the output shows, tail holds the second entry
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (count_reg == 2'd2) begin
                head_reg <= tail_reg;
            end else if (push) begin
                head_reg <= push_data;
            end
        end else if (push && count_reg == 2'd0) begin
            head_reg <= push_data;
        end
        if (push && ((count_reg == 2'd1 && !pop) || (count_reg == 2'd2 && pop))) begin
            tail_reg <= push_data;
        end
    end

endmodule

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger top level: trigger pulse, echo timing and distance.
// A result is valid on the cycle after its input transfer if the buffer is empty.
// Throughput: one item per cycle; a two-entry output buffer holds waiting results,
// and s_tready drops only while both entries are full.
// Reset (aresetn low, synchronous): phase idle, counters and distance zero,
// registers back to timeout 12500 and trigger 3 ticks, output buffer empty.
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]  cfg_wdata,
    // input channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [0] echo_level, [7:1] zero
    input  logic                       s_tuser,   // [0] command
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata    // [0] trigger_out, [1] busy_res,
                                                  // [2] done_res, [3] timed_out,
                                                  // [19:4] distance_mm, [23:20] zero
);

    logic [uer_pkg::TICK_W-1:0]  timeout_reg;
    logic [uer_pkg::PULSE_W-1:0] trigger_reg;

    uer_pkg::phase_t             phase_reg, phase_next;
    logic [uer_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic [uer_pkg::PULSE_W-1:0] pulse_reg, pulse_next;
    logic [uer_pkg::DIST_W-1:0]  dist_reg, dist_next;
    logic                        tflag_reg, tflag_next;
    logic                        done;

    logic                        s_fire;
    logic                        command;
    logic                        echo;
    logic [uer_pkg::TICK_W-1:0]  tick_inc;
    logic [uer_pkg::PULSE_W-1:0] pulse_inc;
    logic                        timeout_hit;
    logic [uer_pkg::PROD_W-1:0]  product;
    logic [uer_pkg::DIST_W-1:0]  dist_calc;

    uer_pkg::result_t            res_next;
    uer_pkg::result_t            res_out;

    assign s_fire  = s_tvalid && s_tready;
    assign command = s_tuser;
    assign echo    = s_tdata[0];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= uer_pkg::TIMEOUT_RESET;
            trigger_reg <= uer_pkg::TRIGGER_RESET;
        end else if (cfg_we) begin
            unique case (uer_pkg::cfg_idx_t'(cfg_index))
                uer_pkg::CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                uer_pkg::CFG_TRIGGER: trigger_reg <= cfg_wdata[uer_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturating tick counter, timeout compare and distance scaling
    assign tick_inc    = (tick_reg != uer_pkg::TICK_MAX) ? tick_reg + 16'd1 : tick_reg;
    assign pulse_inc   = pulse_reg + 8'd1;
    assign timeout_hit = (tick_inc >= timeout_reg);
    assign product     = {{uer_pkg::DIST_MULT_W{1'b0}}, tick_inc} *
                         {{uer_pkg::TICK_W{1'b0}}, uer_pkg::DIST_MULT};
    assign dist_calc   = product[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_W];

    // Phase sequencing per transfer
    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        pulse_next = pulse_reg;
        dist_next  = dist_reg;
        tflag_next = tflag_reg;
        done       = 1'b0;
        if (command) begin
            if (phase_reg == uer_pkg::PH_IDLE) begin
                phase_next = uer_pkg::PH_TRIGGER;
                pulse_next = '0;
            end
        end else begin
            unique case (phase_reg)
                uer_pkg::PH_IDLE: ;
                uer_pkg::PH_TRIGGER: begin
                    pulse_next = pulse_inc;
                    if (pulse_inc >= trigger_reg) begin
                        tick_next  = '0;
                        phase_next = uer_pkg::PH_WAIT_RISE;
                    end
                end
                uer_pkg::PH_WAIT_RISE: begin
                    tick_next = tick_inc;
                    if (timeout_hit) begin
                        dist_next  = uer_pkg::TIMEOUT_DISTANCE;
                        tflag_next = 1'b1;
                        phase_next = uer_pkg::PH_IDLE;
                        done       = 1'b1;
                    end else if (echo) begin
                        tick_next  = '0;
                        phase_next = uer_pkg::PH_MEASURE;
                    end
                end
                uer_pkg::PH_MEASURE: begin
                    tick_next = tick_inc;
                    if (timeout_hit) begin
                        dist_next  = uer_pkg::TIMEOUT_DISTANCE;
                        tflag_next = 1'b1;
                        phase_next = uer_pkg::PH_IDLE;
                        done       = 1'b1;
                    end else if (!echo) begin
                        dist_next  = dist_calc;
                        tflag_next = 1'b0;
                        phase_next = uer_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= uer_pkg::PH_IDLE;
            tick_reg  <= '0;
            pulse_reg <= '0;
            dist_reg  <= '0;
            tflag_reg <= 1'b0;
        end else if (s_fire) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            pulse_reg <= pulse_next;
            dist_reg  <= dist_next;
            tflag_reg <= tflag_next;
        end
    end

    // Result of this transfer
    always_comb begin
        res_next.trigger_out = (phase_next == uer_pkg::PH_TRIGGER);
        res_next.busy_res    = (phase_next != uer_pkg::PH_IDLE);
        res_next.done_res    = done;
        res_next.timed_out   = tflag_next;
        res_next.distance_mm = dist_next;
    end

    uer_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_fire),
        .push_data (res_next),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = {4'd0, res_out.distance_mm, res_out.timed_out, res_out.done_res,
                      res_out.busy_res, res_out.trigger_out};

    // A finished measurement leaves the sequencer idle
    `UER_ASSERT_NEXT(a_done_idle, s_fire && done, phase_reg == uer_pkg::PH_IDLE)
    // A timed-out result always carries the timeout distance
    `UER_ASSERT_IMPL(a_timeout_dist, m_tvalid && m_tdata[3], m_tdata[19:4] == 16'hFFFF)
    // Trigger high only during a measurement
    `UER_ASSERT_IMPL(a_trig_busy, m_tvalid && m_tdata[0], m_tdata[1])
    // Input stalls only when results are waiting
    `UER_ASSERT_IMPL(a_stall_full, !s_tready, m_tvalid)

endmodule
